### hdl/key_press_mode_selector_defines.svh
// Assertion macros used by the checker file of the key press mode selector.
`ifndef KEY_PRESS_MODE_SELECTOR_DEFINES_SVH
`define KEY_PRESS_MODE_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPMS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KPMS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

### hdl/kpms_pkg.sv
// Types and codes of the key press mode selector.
package kpms_pkg;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PRESS = 2'd1;
	localparam logic [1:0] PH_LONG  = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	localparam logic [2:0] MODE_LAST = 3'd4;
	localparam logic [1:0] OHM_LAST  = 2'd3;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 8'd1;

	localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0]  phase;
		logic [31:0] press_stamp;
		logic        prev_level;
		logic [2:0]  mode;
		logic        vrange;
		logic [1:0]  rrange;
	} kpms_state_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
	} kpms_cfg_t;

endpackage

### hdl/key_press_mode_selector.sv
// Top level of the key press mode selector: input register, step logic, result register.
// The input register feeds kpms_step; its result and the next state are registered together at adv.
// Throughput: one poll per cycle unless stalled; the state update is one pass of kpms_step.
// A stalled result holds the result stage; input is still taken while stage one is free.
// Reset (arst_n low, asynchronous): phase idle, all state zero, debounce 20 ms,
// long press 1000 ms, both stages empty.
module key_press_mode_selector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // key_level [0], now_ms [32:1], zero [39:33]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // key_event [1:0], main_mode [4:2], volt_range [5],
	                               // ohm_range [7:6], press_phase [9:8], zero [15:10]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [kpms_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic                  v_s1;
	logic                  key_s1;
	logic [31:0]           now_s1;
	logic                  v_s2;
	logic [15:0]           data_s2;
	kpms_pkg::kpms_state_t state_q;
	kpms_pkg::kpms_state_t state_nxt;
	kpms_pkg::kpms_cfg_t   cfg_q;
	logic [1:0]            event_nxt;
	logic                  adv;

	assign adv       = v_s1 && (!v_s2 || m_tready);
	assign s_tready  = !v_s1 || !v_s2 || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = v_s2;
	assign m_tdata   = data_s2;

	kpms_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.key_level (key_s1),
		.now_ms    (now_s1),
		.nxt       (state_nxt),
		.key_event (event_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= kpms_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_ms <= kpms_pkg::LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == kpms_pkg::REG_DEBOUNCE) begin
				cfg_q.debounce_ms <= cfg_data;
			end else if (cfg_index == kpms_pkg::REG_LONG_PRESS) begin
				cfg_q.long_press_ms <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			state_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2    <= 1'b1;
				state_q <= state_nxt;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
		if (adv) begin
			data_s2 <= {6'd0, state_nxt.phase, state_nxt.rrange, state_nxt.vrange,
				state_nxt.mode, event_nxt};
		end
	end

endmodule

### hdl/kpms_step.sv
// Next-state and event logic for one key poll.
module kpms_step (
	input  kpms_pkg::kpms_state_t cur,
	input  kpms_pkg::kpms_cfg_t   cfg,
	input  logic                  key_level,
	input  logic [31:0]           now_ms,
	output kpms_pkg::kpms_state_t nxt,
	output logic [1:0]            key_event
);

	logic [31:0] held;
	logic        debounced;
	logic        long_hit;

	assign held      = now_ms - cur.press_stamp;
	assign debounced = held >= {16'd0, cfg.debounce_ms};
	assign long_hit  = held >= {16'd0, cfg.long_press_ms};

	always_comb begin
		nxt            = cur;
		key_event      = kpms_pkg::EV_NONE;
		nxt.prev_level = key_level;
		unique case (cur.phase)
			kpms_pkg::PH_PRESS: begin
				if (debounced) begin
					if (key_level) begin
						if (long_hit) begin
							nxt.mode  = (cur.mode >= kpms_pkg::MODE_LAST) ? 3'd0
								: cur.mode + 3'd1;
							key_event = kpms_pkg::EV_LONG;
							nxt.phase = kpms_pkg::PH_LONG;
						end
					end else begin
						if (cur.mode == 3'd1 || cur.mode == 3'd2) begin
							nxt.vrange = ~cur.vrange;
						end
						if (cur.mode == 3'd3) begin
							nxt.rrange = (cur.rrange >= kpms_pkg::OHM_LAST) ? 2'd0
								: cur.rrange + 2'd1;
						end
						key_event = kpms_pkg::EV_SHORT;
						nxt.phase = kpms_pkg::PH_IDLE;
					end
				end
			end
			kpms_pkg::PH_LONG: begin
				if (!key_level) begin
					nxt.phase = kpms_pkg::PH_IDLE;
				end
			end
			default: begin
				if (key_level && !cur.prev_level) begin
					nxt.press_stamp = now_ms;
					nxt.phase       = kpms_pkg::PH_PRESS;
				end
			end
		endcase
	end

endmodule

### hdl/kpms_checker.sv
// Port-level assertions of the key press mode selector and their bind.
`include "key_press_mode_selector_defines.svh"

module kpms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [1:0] out_event;
	logic [2:0] out_mode;
	logic [1:0] out_phase;
	logic [5:0] out_pad;

	assign out_event = m_tdata[1:0];
	assign out_mode  = m_tdata[4:2];
	assign out_phase = m_tdata[9:8];
	assign out_pad   = m_tdata[15:10];

	`KPMS_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`KPMS_ASSERT_IMPLY(a_long_phase, clk, arst_n, m_tvalid && out_event == kpms_pkg::EV_LONG, out_phase == kpms_pkg::PH_LONG)
	`KPMS_ASSERT_IMPLY(a_short_idle, clk, arst_n, m_tvalid && out_event == kpms_pkg::EV_SHORT, out_phase == kpms_pkg::PH_IDLE)
	`KPMS_ASSERT_IMPLY(a_mode_range, clk, arst_n, m_tvalid, out_mode <= kpms_pkg::MODE_LAST && out_pad == 6'd0)

endmodule

bind key_press_mode_selector kpms_checker u_kpms_checker (.*);

### tb/key_press_mode_selector_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench of the key press mode selector with its own press predictor.
module key_press_mode_selector_test;

	localparam logic [kpms_pkg::CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
	localparam logic [2:0] VOLT_MODE_FIRST = 3'd1;
	localparam logic [2:0] VOLT_MODE_LAST  = 3'd2;
	localparam logic [2:0] OHM_MODE        = 3'd3;
	localparam int STUCK_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] ohm;
		logic       volt;
		logic [2:0] mode;
		logic [1:0] ev;
	} selector_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [kpms_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	logic [1:0]  sel_phase;
	logic [31:0] sel_stamp;
	logic        sel_prev;
	logic [2:0]  sel_mode;
	logic        sel_vrange;
	logic [1:0]  sel_rrange;
	logic [15:0] cfg_debounce;
	logic [15:0] cfg_long;

	selector_out_t pending_outputs[$];
	logic [31:0] poll_clock;
	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int stuck_cycles;

	key_press_mode_selector dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic selector_out_t advance_selector(input logic key, input logic [31:0] now);
		logic [31:0] held;
		selector_out_t res;
		res.ev = kpms_pkg::EV_NONE;
		held = now - sel_stamp;
		case (sel_phase)
		kpms_pkg::PH_PRESS: begin
			if (held >= {16'd0, cfg_debounce}) begin
				if (key) begin
					if (held >= {16'd0, cfg_long}) begin
						sel_mode = (sel_mode >= kpms_pkg::MODE_LAST) ? 3'd0
							: sel_mode + 3'd1;
						res.ev = kpms_pkg::EV_LONG;
						sel_phase = kpms_pkg::PH_LONG;
					end
				end else begin
					if (sel_mode == VOLT_MODE_FIRST || sel_mode == VOLT_MODE_LAST)
						sel_vrange = ~sel_vrange;
					if (sel_mode == OHM_MODE)
						sel_rrange = (sel_rrange >= kpms_pkg::OHM_LAST) ? 2'd0
							: sel_rrange + 2'd1;
					res.ev = kpms_pkg::EV_SHORT;
					sel_phase = kpms_pkg::PH_IDLE;
				end
			end
		end
		kpms_pkg::PH_LONG: begin
			if (!key)
				sel_phase = kpms_pkg::PH_IDLE;
		end
		default: begin
			if (key && !sel_prev) begin
				sel_stamp = now;
				sel_phase = kpms_pkg::PH_PRESS;
			end
		end
		endcase
		sel_prev = key;
		res.mode = sel_mode;
		res.volt = sel_vrange;
		res.ohm = sel_rrange;
		res.phase = sel_phase;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// one poll per transfer; the expectation is formed at the accepting edge
	task automatic send_poll(input logic key, input logic [31:0] now);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, now, key};
		do @(posedge clk); while (!s_tready);
		pending_outputs.push_back(advance_selector(key, now));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [kpms_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] value);
		s_tvalid = 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == kpms_pkg::REG_DEBOUNCE)
			cfg_debounce = value;
		else if (idx == kpms_pkg::REG_LONG_PRESS)
			cfg_long = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_presses(input int count);
		int sent;
		int step;
		int hold;
		int rel;
		int r;
		logic key;
		sent = 0;
		step = ((cfg_debounce > cfg_long) ? cfg_debounce : cfg_long) / 3;
		if (step < 1)
			step = 1;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 10)
				poll_clock = $urandom();
			else if (r < 14)
				poll_clock = 32'hFFFF_FFFF - $urandom_range(2 * step);
			if (r >= 90) begin
				if ($urandom_range(1))
					send_poll(1'($urandom_range(1)), $urandom());
				else
					send_poll(1'($urandom_range(1)), poll_clock);
				poll_clock = poll_clock + $urandom_range(step);
				sent++;
			end else begin
				hold = $urandom_range(1, 6);
				rel = $urandom_range(1, 3);
				for (int i = 0; i < hold + rel; i++) begin
					if (i >= hold)
						key = 1'b0;
					else if (i > 0 && $urandom_range(5) == 0)
						key = 1'b0;
					else
						key = 1'b1;
					send_poll(key, poll_clock);
					poll_clock = poll_clock + $urandom_range(step);
					sent++;
				end
			end
		end
		s_tvalid = 1'b0;
	endtask

	task automatic test_directed();
		send_poll(1'b0, 32'h0000_0000);
		send_poll(1'b0, 32'hFFFF_FFFF);
		send_poll(1'b1, 32'hFFFF_FFF0);
		send_poll(1'b0, 32'hFFFF_FFF8);
		send_poll(1'b1, 32'h0000_0004);
		send_poll(1'b0, 32'h0000_0010);
		send_poll(1'b1, 32'd100);
		send_poll(1'b1, 32'd1100);
		send_poll(1'b1, 32'd1200);
		send_poll(1'b0, 32'd1300);
		send_poll(1'b1, 32'd1400);
		send_poll(1'b0, 32'd1450);
		send_poll(1'b1, 32'd2000);
		send_poll(1'b1, 32'd3500);
		send_poll(1'b0, 32'd3600);
		send_poll(1'b1, 32'd4000);
		send_poll(1'b0, 32'd4100);
		send_poll(1'b1, 32'd5000);
		send_poll(1'b1, 32'd6000);
		send_poll(1'b0, 32'd6001);
		send_poll(1'b1, 32'd7000);
		send_poll(1'b0, 32'd7030);
		send_poll(1'b1, 32'hAAAA_5555);
		send_poll(1'b0, 32'h5555_AAAA);
		s_tvalid = 1'b0;
	endtask

	task automatic test_config_extremes();
		write_reg(kpms_pkg::REG_DEBOUNCE, 16'd0);
		write_reg(kpms_pkg::REG_LONG_PRESS, 16'd0);
		send_presses(100);
		write_reg(kpms_pkg::REG_DEBOUNCE, 16'hFFFF);
		write_reg(kpms_pkg::REG_LONG_PRESS, 16'hFFFF);
		send_presses(100);
		write_reg(kpms_pkg::REG_DEBOUNCE, 16'd50);
		write_reg(kpms_pkg::REG_LONG_PRESS, 16'd10);
		write_reg(REG_SPARE, 16'h0001);
		send_presses(100);
		write_reg(kpms_pkg::REG_DEBOUNCE, 16'hFFFF);
		write_reg(kpms_pkg::REG_LONG_PRESS, 16'd0);
		send_presses(100);
	endtask

	task automatic test_idle_phases();
		for (int p = 0; p < 4; p++) begin
			write_reg(kpms_pkg::REG_DEBOUNCE, 16'($urandom_range(100)));
			write_reg(kpms_pkg::REG_LONG_PRESS, 16'($urandom_range(400)));
			case (p)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			send_presses(200);
		end
	endtask

	task automatic test_backpressure();
		write_reg(kpms_pkg::REG_DEBOUNCE, kpms_pkg::DEBOUNCE_RESET);
		write_reg(kpms_pkg::REG_LONG_PRESS, kpms_pkg::LONG_PRESS_RESET);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		send_presses(40);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			m_tready = !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		selector_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected transfer, key_event", m_tdata[1:0], -1);
			end else begin
				want = pending_outputs.pop_front();
				if (m_tdata[1:0] != want.ev)
					report_mismatch("key_event", m_tdata[1:0], want.ev);
				if (m_tdata[4:2] != want.mode)
					report_mismatch("main_mode", m_tdata[4:2], want.mode);
				if (m_tdata[5] != want.volt)
					report_mismatch("volt_range", m_tdata[5], want.volt);
				if (m_tdata[7:6] != want.ohm)
					report_mismatch("ohm_range", m_tdata[7:6], want.ohm);
				if (m_tdata[9:8] != want.phase)
					report_mismatch("press_phase", m_tdata[9:8], want.phase);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		stuck_cycles = 0;
		poll_clock = 32'd0;
		sel_phase = kpms_pkg::PH_IDLE;
		sel_stamp = 32'd0;
		sel_prev = 1'b0;
		sel_mode = 3'd0;
		sel_vrange = 1'b0;
		sel_rrange = 2'd0;
		cfg_debounce = kpms_pkg::DEBOUNCE_RESET;
		cfg_long = kpms_pkg::LONG_PRESS_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_config_extremes();
		test_idle_phases();
		test_backpressure();

		s_tvalid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0)
			report_mismatch("outstanding expectations", 0, pending_outputs.size());
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
